// ===== hdl/bmcc_pkg.sv =====
// bmcc_pkg: shared types and constants for the button multi-click classifier.
// Used by the channel interfaces, bmcc_core and the top level.
// No dependencies.
package bmcc_pkg;

    // counter, tally, event code and config index widths
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned TALLY_W = 4;
    localparam int unsigned EVT_W   = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_DB   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPRESS_DB = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_WIN  = 2'd3;

    // configuration reset values
    localparam logic [CNT_W-1:0] RST_PRESS_DB   = 16'd20;
    localparam logic [CNT_W-1:0] RST_REPRESS_DB = 16'd2;
    localparam logic [CNT_W-1:0] RST_LONG_PRESS = 16'd1500;
    localparam logic [CNT_W-1:0] RST_CLICK_WIN  = 16'd500;

    // event codes
    localparam logic [EVT_W-1:0] EV_NONE   = 3'd0;
    localparam logic [EVT_W-1:0] EV_SINGLE = 3'd1;
    localparam logic [EVT_W-1:0] EV_DOUBLE = 3'd2;
    localparam logic [EVT_W-1:0] EV_LONG   = 3'd3;
    localparam logic [EVT_W-1:0] EV_TRIPLE = 3'd4;

    // tally values that map to a click event
    localparam logic [TALLY_W-1:0] TALLY_ONE   = 4'd1;
    localparam logic [TALLY_W-1:0] TALLY_TWO   = 4'd2;
    localparam logic [TALLY_W-1:0] TALLY_THREE = 4'd3;

    // classifier phases
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HELD   = 3'd1,
        PH_GAP    = 3'd2,
        PH_LONG   = 3'd3,
        PH_REPORT = 3'd4
    } t_phase;

    // configuration bundle handed to the core
    typedef struct packed {
        logic [CNT_W-1:0] press_db;
        logic [CNT_W-1:0] repress_db;
        logic [CNT_W-1:0] long_press;
        logic [CNT_W-1:0] click_win;
    } t_cfg;

    // saturating increment of a counter
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

endpackage

// ===== hdl/bmcc_if.sv =====
// bmcc_key_if / bmcc_evt_if: valid/ready channels for key samples and events.
// Depends on bmcc_pkg for the event width.
interface bmcc_key_if;
    logic valid;
    logic ready;
    logic key_level;

    modport source (output valid, output key_level, input ready);
    modport sink   (input valid, input key_level, output ready);
endinterface

interface bmcc_evt_if;
    logic                      valid;
    logic                      ready;
    logic [bmcc_pkg::EVT_W-1:0] event_res;

    modport source (output valid, output event_res, input ready);
    modport sink   (input valid, input event_res, output ready);
endinterface

// ===== hdl/button_multi_click_classifier.sv =====
// button_multi_click_classifier: top level; config registers, core, event register.
// Depends on bmcc_pkg, bmcc_if.sv and bmcc_core.
//
//  channel   dir  signals                          beat
//  i_key     in   valid, ready, key_level          one sampled pin level
//  o_evt     out  valid, ready, event_res          one event code per key beat
//  i_cfg_*   in   i_cfg_we, i_cfg_idx, i_cfg_data  one register write
//
// Each key beat updates the state in the cycle it is accepted, and its event
// code is written to the output register in that same cycle: one beat per cycle.
// The single output register sets the rate; a new beat is taken whenever
// that register is empty or being drained in the same cycle.
// Synchronous active-low reset clears state, event valid flag and config to defaults.
module button_multi_click_classifier (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    bmcc_key_if.sink                          i_key,
    bmcc_evt_if.source                        o_evt,
    input  logic                              i_cfg_we,
    input  logic [bmcc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bmcc_pkg::CNT_W-1:0]        i_cfg_data
);

    bmcc_pkg::t_cfg                 r_cfg;
    logic                           r_evt_valid;
    logic [bmcc_pkg::EVT_W-1:0]     r_evt;
    logic [bmcc_pkg::EVT_W-1:0]     core_event;
    logic                           in_ready;
    logic                           step;

    // handshake
    assign in_ready    = ~r_evt_valid | o_evt.ready;
    assign step        = i_key.valid & in_ready;
    assign i_key.ready = in_ready;
    assign o_evt.valid = r_evt_valid;
    assign o_evt.event_res = r_evt;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_db   <= bmcc_pkg::RST_PRESS_DB;
            r_cfg.repress_db <= bmcc_pkg::RST_REPRESS_DB;
            r_cfg.long_press <= bmcc_pkg::RST_LONG_PRESS;
            r_cfg.click_win  <= bmcc_pkg::RST_CLICK_WIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bmcc_pkg::CFG_PRESS_DB:   r_cfg.press_db   <= i_cfg_data;
                bmcc_pkg::CFG_REPRESS_DB: r_cfg.repress_db <= i_cfg_data;
                bmcc_pkg::CFG_LONG_PRESS: r_cfg.long_press <= i_cfg_data;
                bmcc_pkg::CFG_CLICK_WIN:  r_cfg.click_win  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bmcc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_key_level (i_key.key_level),
        .i_cfg       (r_cfg),
        .o_event     (core_event)
    );

    // event output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_evt_valid <= 1'b0;
        end else if (step) begin
            r_evt_valid <= 1'b1;
        end else if (o_evt.ready) begin
            r_evt_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_evt <= core_event;
        end
    end

endmodule

// ===== hdl/bmcc_core.sv =====
// bmcc_core: phase machine, debounce/hold and window counters, click tally.
// Advances one tick per i_step; depends on bmcc_pkg.
module bmcc_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic                         i_key_level,
    input  bmcc_pkg::t_cfg               i_cfg,
    output logic [bmcc_pkg::EVT_W-1:0]   o_event
);

    bmcc_pkg::t_phase                  r_phase, n_phase;
    logic [bmcc_pkg::CNT_W-1:0]        r_hold, n_hold;
    logic [bmcc_pkg::CNT_W-1:0]        r_win, n_win;
    logic [bmcc_pkg::TALLY_W-1:0]      r_tally, n_tally;

    logic                              pressed;
    logic [bmcc_pkg::CNT_W-1:0]        hold_inc;
    logic [bmcc_pkg::CNT_W-1:0]        win_inc;

    assign pressed  = ~i_key_level;
    assign hold_inc = bmcc_pkg::sat_inc(r_hold);
    assign win_inc  = bmcc_pkg::sat_inc(r_win);

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            bmcc_pkg::PH_IDLE: begin
                if (pressed && hold_inc >= i_cfg.press_db) n_phase = bmcc_pkg::PH_HELD;
            end
            bmcc_pkg::PH_HELD: begin
                if (!pressed)                         n_phase = bmcc_pkg::PH_GAP;
                else if (hold_inc > i_cfg.long_press) n_phase = bmcc_pkg::PH_LONG;
            end
            bmcc_pkg::PH_GAP: begin
                if (win_inc >= i_cfg.click_win)       n_phase = bmcc_pkg::PH_REPORT;
                else if (pressed && hold_inc >= i_cfg.repress_db)
                                                      n_phase = bmcc_pkg::PH_HELD;
            end
            bmcc_pkg::PH_LONG: begin
                if (!pressed) n_phase = bmcc_pkg::PH_IDLE;
            end
            bmcc_pkg::PH_REPORT: n_phase = bmcc_pkg::PH_IDLE;
            default:             n_phase = bmcc_pkg::PH_IDLE;
        endcase
    end

    // counters, tally and event code
    always_comb begin
        n_hold  = r_hold;
        n_win   = r_win;
        n_tally = r_tally;
        o_event = bmcc_pkg::EV_NONE;
        unique case (r_phase)
            bmcc_pkg::PH_IDLE: begin
                if (pressed) begin
                    n_hold = (hold_inc >= i_cfg.press_db) ? '0 : hold_inc;
                end else begin
                    n_hold = '0;
                    n_win  = '0;
                end
            end
            bmcc_pkg::PH_HELD: begin
                n_win = win_inc;
                if (!pressed) begin
                    n_hold = '0;
                    if (r_tally != bmcc_pkg::TALLY_MAX) n_tally = r_tally + 1'b1;
                end else if (hold_inc > i_cfg.long_press) begin
                    n_hold  = '0;
                    o_event = bmcc_pkg::EV_LONG;
                end else begin
                    n_hold = hold_inc;
                end
            end
            bmcc_pkg::PH_GAP: begin
                if (win_inc >= i_cfg.click_win) begin
                    n_win = '0;
                end else begin
                    n_win = win_inc;
                    if (pressed)
                        n_hold = (hold_inc >= i_cfg.repress_db) ? '0 : hold_inc;
                    else
                        n_hold = '0;
                end
            end
            bmcc_pkg::PH_LONG: ;
            bmcc_pkg::PH_REPORT: begin
                n_tally = '0;
                case (r_tally)
                    bmcc_pkg::TALLY_ONE:   o_event = bmcc_pkg::EV_SINGLE;
                    bmcc_pkg::TALLY_TWO:   o_event = bmcc_pkg::EV_DOUBLE;
                    bmcc_pkg::TALLY_THREE: o_event = bmcc_pkg::EV_TRIPLE;
                    default:               o_event = bmcc_pkg::EV_NONE;
                endcase
            end
            default: ;
        endcase
    end

    // state registers, advanced once per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bmcc_pkg::PH_IDLE;
            r_hold  <= '0;
            r_win   <= '0;
            r_tally <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_hold  <= n_hold;
            r_win   <= n_win;
            r_tally <= n_tally;
        end
    end

endmodule
